// ===== sv/chained_hash_map_top_defines.svh =====
// Assertion helpers for the chained hash map.
`ifndef CHAINED_HASH_MAP_TOP_DEFINES_SVH
`define CHAINED_HASH_MAP_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define CMH_ASSERT(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);
`define CMH_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define CMH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CMH_ASSERT(label, expr, msg)
`define CMH_ASSERT_IMP(label, ante, cons, msg)
`define CMH_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== sv/cmh_pkg.sv =====
`default_nettype none
package cmh_pkg;
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_GET    = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef struct packed {
        logic start;
        logic [KEY_W-1:0] key;
    } bkt_req_t;
endpackage
`default_nettype wire

// ===== sv/cmh_ram.sv =====
`default_nettype none
module cmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== sv/cmh_bucket.sv =====
`default_nettype none
module cmh_bucket #(
    parameter int BUCKETS = 13,
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cmh_pkg::bkt_req_t req,
    output logic                   done,
    output logic [BW-1:0]          bucket
);
    import cmh_pkg::*;

    localparam int SW = 20;
    localparam int RW = BW + 1;
    localparam logic [RW-1:0] BUCK = RW'(BUCKETS);
    // weight of each key byte: 2^(8k) mod BUCKETS
    localparam logic [SW-1:0] W0   = SW'(1 % BUCKETS);
    localparam logic [SW-1:0] W1   = SW'(256 % BUCKETS);
    localparam logic [SW-1:0] W2   = SW'(65536 % BUCKETS);
    localparam logic [SW-1:0] W3   = SW'(16777216 % BUCKETS);
    localparam logic [SW-1:0] BMUL = SW'(BUCKETS);
    localparam logic [43:0]   RECIP = 44'((1 << 24) / BUCKETS);

    logic [KEY_W-1:0] mag_reg, mag_next;
    logic             neg_reg, neg_next;
    logic [SW-1:0]    sum_reg, sum_next;
    logic [SW-1:0]    q_reg, q_next;
    logic [RW-1:0]    diff_reg, diff_next;
    logic [BW-1:0]    rem_reg, rem_next;
    logic [3:0]       stg_reg, stg_next;
    logic             done_reg, done_next;
    logic [43:0]      prod;
    logic [SW-1:0]    qb;
    logic [RW-1:0]    corr;

    // Pipeline: fold bytes, estimate quotient, subtract, correct and fold sign.
    always_comb begin
        mag_next = mag_reg;
        neg_next = neg_reg;
        if (req.start) begin
            neg_next = req.key[KEY_W-1];
            mag_next = req.key[KEY_W-1] ? (~req.key + 1'b1) : req.key;
        end
        sum_next = SW'(mag_reg[7:0]) * W0 + SW'(mag_reg[15:8]) * W1
                 + SW'(mag_reg[23:16]) * W2 + SW'(mag_reg[31:24]) * W3;
        // quotient estimate is exact or one short
        prod      = 44'(sum_reg) * RECIP;
        q_next    = prod[43:24];
        qb        = q_reg * BMUL;
        diff_next = RW'(sum_reg - qb);
        corr      = (diff_reg >= BUCK) ? diff_reg - BUCK : diff_reg;
        // fold a negative magnitude back to the non-negative remainder
        if (neg_reg && corr != '0) begin
            rem_next = BW'(BUCK - corr);
        end else begin
            rem_next = BW'(corr);
        end
        stg_next  = {stg_reg[2:0], req.start};
        done_next = stg_reg[3];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            stg_reg  <= stg_next;
            done_reg <= done_next;
        end
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        sum_reg  <= sum_next;
        q_reg    <= q_next;
        diff_reg <= diff_next;
        rem_reg  <= rem_next;
    end

    assign done   = done_reg;
    assign bucket = rem_reg;
endmodule
`default_nettype wire

// ===== sv/chained_hash_map_top.sv =====
`default_nettype none
// Key-value map with separate chaining over a fixed node pool.
// Input channel s_*: one request per handshake carrying mode (insert, remove,
// get or none), a signed key and a value. Output channel m_*: exactly one
// result per request, in order: flag, read value and pool-full.
// Sequence: the bucket index is computed from the accepted key, then each
// chain node visited takes a node memory read, then a compare; the end of
// the chain is seen on the read step, write-back follows where needed and
// the result moves into the output register.
// One request is in flight at a time; s_tready rises again once the result
// has moved to the output register, so the next request may enter while the
// previous result still waits there.
// Reset: after aresetn the block sweeps the link memory to build the free
// list with s_tready low, then accepts requests.
// A stalled receiver holds the result in the output register; a finished
// request then waits before it moves out, and no new request is taken.
module chained_hash_map_top #(
    parameter int BUCKETS = 13,
    parameter int NODES   = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [1:0] mode, [33:2] lookup_key, [65:34] new_value, [71:66] zero
    input  wire logic [71:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] flag, [32:1] read_value, [33] pool_full, [39:34] zero
    output logic [39:0]      m_tdata
);
    import cmh_pkg::*;

    `include "chained_hash_map_top_defines.svh"

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int PW = $clog2(NODES + 1);
    localparam logic [PW-1:0] NIL  = PW'(NODES);
    localparam logic [PW-1:0] LAST = PW'(NODES - 1);

    typedef enum logic [9:0] {
        ST_INIT     = 10'b0000000001,
        ST_IDLE     = 10'b0000000010,
        ST_HASH     = 10'b0000000100,
        ST_RD       = 10'b0000001000,
        ST_CMP      = 10'b0000010000,
        ST_ALLOC_RD = 10'b0000100000,
        ST_ALLOC    = 10'b0001000000,
        ST_LINK     = 10'b0010000000,
        ST_REM      = 10'b0100000000,
        ST_RESP     = 10'b1000000000
    } state_t;

    state_t            state_reg, state_next;
    logic [PW-1:0]     init_reg, init_next;
    logic [PW-1:0]     free_reg, free_next;
    logic [PW-1:0]     cur_reg, cur_next;
    logic [PW-1:0]     prev_reg, prev_next;
    logic [PW-1:0]     steps_reg, steps_next;
    mode_t             mode_reg, mode_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [VAL_W-1:0]  val_reg, val_next;
    logic              flag_reg, flag_next;
    logic [VAL_W-1:0]  rv_reg, rv_next;
    logic              full_reg, full_next;
    logic              m_valid_reg, m_valid_next;
    logic [39:0]       m_data_reg, m_data_next;
    logic [PW-1:0]     head_reg [BUCKETS];
    logic              head_we;
    logic [PW-1:0]     head_wdata;

    bkt_req_t          bkt_req;
    logic              bkt_done;
    logic [BW-1:0]     bucket;

    logic [AW-1:0]     rd_addr;
    logic [KEY_W-1:0]  key_rdata;
    logic [VAL_W-1:0]  val_rdata;
    logic [PW-1:0]     next_rdata;
    logic              key_we, val_we, next_we;
    logic [AW-1:0]     key_waddr, val_waddr, next_waddr;
    logic [VAL_W-1:0]  val_wdata;
    logic [PW-1:0]     next_wdata;
    logic              s_fire;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign bkt_req.start = s_fire;
    assign bkt_req.key   = s_tdata[33:2];

    cmh_bucket #(.BUCKETS(BUCKETS)) u_bucket (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (bkt_req),
        .done    (bkt_done),
        .bucket  (bucket)
    );

    assign rd_addr = (state_reg == ST_ALLOC_RD) ? free_reg[AW-1:0] : cur_reg[AW-1:0];

    cmh_ram #(.WIDTH(KEY_W), .DEPTH(NODES)) u_key_ram (
        .aclk(aclk), .we(key_we), .waddr(key_waddr), .wdata(key_reg),
        .raddr(rd_addr), .rdata(key_rdata)
    );
    cmh_ram #(.WIDTH(VAL_W), .DEPTH(NODES)) u_val_ram (
        .aclk(aclk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
        .raddr(rd_addr), .rdata(val_rdata)
    );
    cmh_ram #(.WIDTH(PW), .DEPTH(NODES)) u_next_ram (
        .aclk(aclk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
        .raddr(rd_addr), .rdata(next_rdata)
    );

    always_comb begin
        state_next   = state_reg;
        init_next    = init_reg;
        free_next    = free_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        steps_next   = steps_reg;
        mode_next    = mode_reg;
        key_next     = key_reg;
        val_next     = val_reg;
        flag_next    = flag_reg;
        rv_next      = rv_reg;
        full_next    = full_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        head_we      = 1'b0;
        head_wdata   = NIL;
        key_we       = 1'b0;
        key_waddr    = cur_reg[AW-1:0];
        val_we       = 1'b0;
        val_waddr    = cur_reg[AW-1:0];
        val_wdata    = val_reg;
        next_we      = 1'b0;
        next_waddr   = cur_reg[AW-1:0];
        next_wdata   = NIL;

        unique case (state_reg)
            ST_INIT: begin
                next_we    = 1'b1;
                next_waddr = init_reg[AW-1:0];
                next_wdata = init_reg + 1'b1;
                init_next  = init_reg + 1'b1;
                if (init_reg == LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    mode_next  = mode_t'(s_tdata[1:0]);
                    key_next   = s_tdata[33:2];
                    val_next   = s_tdata[65:34];
                    flag_next  = 1'b0;
                    rv_next    = '0;
                    full_next  = 1'b0;
                    state_next = ST_HASH;
                end
            end
            ST_HASH: begin
                if (bkt_done) begin
                    cur_next   = head_reg[bucket];
                    prev_next  = NIL;
                    steps_next = '0;
                    state_next = (mode_reg == MODE_NONE) ? ST_RESP : ST_RD;
                end
            end
            ST_RD: begin
                if (cur_reg >= NIL || steps_reg >= NIL) begin
                    // end of chain: the key is absent
                    unique case (mode_reg)
                        MODE_INSERT: begin
                            if (free_reg >= NIL) begin
                                full_next  = 1'b1;
                                state_next = ST_RESP;
                            end else begin
                                state_next = ST_ALLOC_RD;
                            end
                        end
                        MODE_GET: begin
                            rv_next    = '1;
                            state_next = ST_RESP;
                        end
                        default: state_next = ST_RESP;
                    endcase
                end else begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                if (key_rdata == key_reg) begin
                    unique case (mode_reg)
                        MODE_INSERT: begin
                            val_we     = 1'b1;
                            state_next = ST_RESP;
                        end
                        MODE_REMOVE: begin
                            // unlink: predecessor or bucket head takes the successor
                            if (prev_reg < NIL) begin
                                next_we    = 1'b1;
                                next_waddr = prev_reg[AW-1:0];
                                next_wdata = next_rdata;
                            end else begin
                                head_we    = 1'b1;
                                head_wdata = next_rdata;
                            end
                            state_next = ST_REM;
                        end
                        MODE_GET: begin
                            flag_next  = 1'b1;
                            rv_next    = val_rdata;
                            state_next = ST_RESP;
                        end
                        default: state_next = ST_RESP;
                    endcase
                end else begin
                    prev_next  = cur_reg;
                    cur_next   = next_rdata;
                    steps_next = steps_reg + 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_REM: begin
                next_we    = 1'b1;
                next_wdata = free_reg;
                free_next  = cur_reg;
                flag_next  = 1'b1;
                state_next = ST_RESP;
            end
            ST_ALLOC_RD: begin
                state_next = ST_ALLOC;
            end
            ST_ALLOC: begin
                key_we     = 1'b1;
                key_waddr  = free_reg[AW-1:0];
                val_we     = 1'b1;
                val_waddr  = free_reg[AW-1:0];
                next_we    = 1'b1;
                next_waddr = free_reg[AW-1:0];
                next_wdata = NIL;
                free_next  = next_rdata;
                cur_next   = free_reg;
                flag_next  = 1'b1;
                if (prev_reg < NIL) begin
                    state_next = ST_LINK;
                end else begin
                    head_we    = 1'b1;
                    head_wdata = free_reg;
                    state_next = ST_RESP;
                end
            end
            ST_LINK: begin
                next_we    = 1'b1;
                next_waddr = prev_reg[AW-1:0];
                next_wdata = cur_reg;
                state_next = ST_RESP;
            end
            ST_RESP: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {6'b0, full_reg, rv_reg, flag_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            init_reg    <= '0;
            free_reg    <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < BUCKETS; i++) begin
                head_reg[i] <= NIL;
            end
        end else begin
            state_reg   <= state_next;
            init_reg    <= init_next;
            free_reg    <= free_next;
            m_valid_reg <= m_valid_next;
            if (head_we) begin
                head_reg[bucket] <= head_wdata;
            end
        end
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        steps_reg  <= steps_next;
        mode_reg   <= mode_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        flag_reg   <= flag_next;
        rv_reg     <= rv_next;
        full_reg   <= full_next;
        m_data_reg <= m_data_next;
    end

    `CMH_ASSERT_IMP(a_cmp_in_pool, state_reg == ST_CMP, cur_reg < NIL && steps_reg < NIL, "walk compare outside pool")
    `CMH_ASSERT_IMP(a_full_no_flag, m_valid_reg, !(m_data_reg[0] && m_data_reg[33]), "pool_full with flag")
    `CMH_ASSERT_NEXT(a_accept_busy, s_fire, state_reg == ST_HASH, "accepted request not hashed")
    `CMH_ASSERT_IMP(a_free_range, state_reg != ST_INIT, free_reg <= NIL, "free head out of range")
endmodule
`default_nettype wire

// ===== verif/hash_map_checker.sv =====
`default_nettype none
module hash_map_checker
    import cmh_pkg::*;
#(
    parameter int BUCKETS = 13,
    parameter int NODES   = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [71:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata,
    output int               fail_count,
    output int               pending_count,
    output int               result_count,
    output int               full_count
);
    localparam int NIL = NODES;

    typedef struct packed {
        logic        pool_full;
        logic [31:0] read_value;
        logic        flag;
    } map_result_t;

    int          chain_head [BUCKETS];
    logic [31:0] pool_key   [NODES];
    logic [31:0] pool_value [NODES];
    int          pool_link  [NODES];
    int          free_node;
    map_result_t result_fifo [$];

    function automatic int bucket_index(logic signed [31:0] key);
        longint r;
        r = longint'(key) % BUCKETS;
        if (r < 0) r += BUCKETS;
        return int'(r);
    endfunction

    // Walk a chain; return the matching node or NIL, and its predecessor.
    function automatic int chain_search(int b, logic [31:0] key, output int pred);
        int cur;
        int steps;
        cur = chain_head[b];
        pred = NIL;
        steps = 0;
        while (cur >= 0 && cur < NODES && steps < NODES) begin
            if (pool_key[cur] == key) return cur;
            pred = cur;
            cur = pool_link[cur];
            steps++;
        end
        return NIL;
    endfunction

    function automatic map_result_t apply_request(mode_t mode, logic [31:0] key,
                                                  logic [31:0] val);
        map_result_t r;
        int b;
        int hit;
        int pred;
        int n;
        r = '0;
        b = bucket_index(key);
        case (mode)
            MODE_INSERT: begin
                hit = chain_search(b, key, pred);
                if (hit < NODES) begin
                    pool_value[hit] = val;
                end else if (free_node >= NODES) begin
                    r.pool_full = 1'b1;
                end else begin
                    n = free_node;
                    free_node = pool_link[n];
                    pool_key[n] = key;
                    pool_value[n] = val;
                    pool_link[n] = NIL;
                    if (pred < NODES) pool_link[pred] = n;
                    else chain_head[b] = n;
                    r.flag = 1'b1;
                end
            end
            MODE_REMOVE: begin
                hit = chain_search(b, key, pred);
                if (hit < NODES) begin
                    if (pred < NODES) pool_link[pred] = pool_link[hit];
                    else chain_head[b] = pool_link[hit];
                    pool_link[hit] = free_node;
                    free_node = hit;
                    r.flag = 1'b1;
                end
            end
            MODE_GET: begin
                hit = chain_search(b, key, pred);
                if (hit < NODES) begin
                    r.read_value = pool_value[hit];
                    r.flag = 1'b1;
                end else begin
                    r.read_value = '1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    assign pending_count = result_fifo.size();

    always @(posedge aclk) begin
        map_result_t exp_r;
        map_result_t got_r;
        if (!aresetn) begin
            for (int i = 0; i < BUCKETS; i++) chain_head[i] = NIL;
            for (int i = 0; i < NODES; i++) begin
                pool_key[i] = '0;
                pool_value[i] = '0;
                pool_link[i] = i + 1;
            end
            free_node = 0;
            result_fifo.delete();
            fail_count <= 0;
            result_count <= 0;
            full_count <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                exp_r = apply_request(mode_t'(s_tdata[1:0]), s_tdata[33:2], s_tdata[65:34]);
                if (exp_r.pool_full) full_count <= full_count + 1;
                result_fifo.push_back(exp_r);
            end
            if (m_tvalid && m_tready) begin
                got_r = m_tdata[33:0];
                result_count <= result_count + 1;
                if (result_fifo.size() == 0) begin
                    $error("result with no request outstanding: %h", m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = result_fifo.pop_front();
                    if (got_r != exp_r) begin
                        if (got_r.flag != exp_r.flag)
                            $error("flag: expected %0d, got %0d", exp_r.flag, got_r.flag);
                        if (got_r.read_value != exp_r.read_value)
                            $error("read_value: expected %0d, got %0d",
                                   $signed(exp_r.read_value), $signed(got_r.read_value));
                        if (got_r.pool_full != exp_r.pool_full)
                            $error("pool_full: expected %0d, got %0d",
                                   exp_r.pool_full, got_r.pool_full);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== verif/tb_chained_hash_map_top.sv =====
`default_nettype none
module tb_chained_hash_map_top;
    import cmh_pkg::*;

    localparam int BUCKETS = 13;
    localparam int NODES   = 64;
    localparam int STALL_LIMIT = 20000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    int          fail_count;
    int          pending_count;
    int          result_count;
    int          full_count;
    int          quiet_cycles;
    bit          idle_ok;
    logic [31:0] key_set [16];
    int          request_count;

    chained_hash_map_top #(.BUCKETS(BUCKETS), .NODES(NODES)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    hash_map_checker #(.BUCKETS(BUCKETS), .NODES(NODES)) checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending_count(pending_count),
        .result_count(result_count), .full_count(full_count)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Random receiver stalls, none while idle_ok is clear.
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= !idle_ok || ($urandom_range(99) >= 11);
    end

    // Watchdog on cycles without any handshake.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_request(mode_t mode, logic [31:0] key, logic [31:0] val);
        while (idle_ok && $urandom_range(99) < 11) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, val, key, mode};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        request_count++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    initial begin
        mode_t       mode;
        logic [31:0] key;
        int          pick;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        idle_ok = 1'b1;
        quiet_cycles = 0;
        request_count = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: key extremes, update in place, miss, remove, unused mode.
        send_request(MODE_GET, 32'h8000_0000, 32'h0);
        send_request(MODE_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(MODE_INSERT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(MODE_INSERT, 32'h0, 32'h0);
        send_request(MODE_INSERT, 32'd13, 32'd5);
        send_request(MODE_INSERT, 32'd26, 32'd6);
        send_request(MODE_INSERT, 32'd13, 32'h1234_5678);
        send_request(MODE_GET, 32'd13, 32'h0);
        send_request(MODE_GET, 32'd26, 32'h0);
        send_request(MODE_GET, 32'd39, 32'h0);
        send_request(MODE_REMOVE, 32'd13, 32'hFFFF_FFFF);
        send_request(MODE_GET, 32'd26, 32'h0);
        send_request(MODE_REMOVE, 32'd13, 32'h0);
        send_request(MODE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(MODE_GET, 32'h8000_0000, 32'h0);
        send_request(MODE_GET, 32'h7FFF_FFFF, 32'h0);
        wait_drained();

        // Fill the pool past its end; long walks, no idling on either side while filling.
        idle_ok = 1'b0;
        for (int i = 0; i < 70; i++)
            send_request(MODE_INSERT, 32'(i * 13 - 400), $urandom());
        send_request(MODE_GET, 32'(69 * 13 - 400), 32'h0);
        send_request(MODE_REMOVE, 32'(5 * 13 - 400), 32'h0);
        send_request(MODE_INSERT, 32'd777, 32'd1);
        idle_ok = 1'b1;
        for (int i = 0; i < 70; i++)
            send_request(MODE_REMOVE, 32'(i * 13 - 400), 32'h0);
        send_request(MODE_REMOVE, 32'd777, 32'h0);
        wait_drained();

        // Random: mostly a small key set so hits and chains build up.
        for (int phase = 0; phase < 4; phase++) begin
            for (int j = 0; j < 16; j++) key_set[j] = $urandom();
            for (int i = 0; i < 380; i++) begin
                pick = $urandom_range(99);
                mode = (pick < 45) ? MODE_INSERT : (pick < 70) ? MODE_REMOVE :
                       (pick < 97) ? MODE_GET : MODE_NONE;
                key = ($urandom_range(9) < 8) ? key_set[$urandom_range(15)] : $urandom();
                send_request(mode, key, $urandom());
            end
            wait_drained();
        end

        s_tvalid <= 1'b0;
        while (pending_count != 0) @(posedge aclk);
        repeat (2 * NODES + 50) @(posedge aclk);
        $display("Sent %0d requests, checked %0d results, %0d pool-full inserts.",
                 request_count, result_count, full_count);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire
